// ===== sv/kvtc_pkg.sv =====
// kvtc_pkg: shared types and constants for the keyword vote text classifier.
// Request and response word structs, cell and score bank control structs.
// No dependencies.
package kvtc_pkg;

   localparam int CLASSES_DEF  = 16;
   localparam int ENTRIES_DEF  = 64;
   localparam int WORD_LEN_DEF = 16;

   localparam logic [1:0] KIND_TEXT = 2'd0;
   localparam logic [1:0] KIND_EOT  = 2'd1;
   localparam logic [1:0] KIND_CHAR = 2'd2;
   localparam logic [1:0] KIND_TAG  = 2'd3;

   localparam logic [7:0]  SPACE_CODE = 8'h20;
   localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_code;
      logic [5:0] entry_index;
      logic [3:0] char_position;
      logic [3:0] entry_class;
      logic [4:0] entry_length;
   } req_type;

   typedef struct packed {
      logic [3:0]  best_class;
      logic [15:0] best_score;
      logic [15:0] words_seen;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic compare;
      logic load;
      logic char_we;
      logic tag_we;
   } cell_ctl_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] cls;
   } vote_type;

   typedef struct packed {
      logic clear;
      logic scan;
      logic scan_first;
   } bank_ctl_type;

endpackage

// ===== sv/kvtc_cell.sv =====
// kvtc_cell: one dictionary entry with its character store and match flag.
// Compares a swept word against its entry and shifts votes down the row.
// Depends on kvtc_pkg.
module kvtc_cell #(
   parameter int CLASSES  = kvtc_pkg::CLASSES_DEF,
   parameter int WORD_LEN = kvtc_pkg::WORD_LEN_DEF,
   parameter int CELL_ID  = 0,
   localparam int AW = $clog2(WORD_LEN),
   localparam int LW = $clog2(WORD_LEN + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  kvtc_pkg::cell_ctl_type ctl,
   input  kvtc_pkg::req_type      wr,
   input  logic [AW-1:0]          rd_addr,
   input  logic [7:0]             word_char,
   input  logic [LW-1:0]          word_len,
   input  kvtc_pkg::vote_type     vote_prev,
   output kvtc_pkg::vote_type     vote_out
);

   logic [7:0] chars [WORD_LEN];
   logic [7:0] rd_ff;
   logic [3:0] dclass_ff;
   logic [4:0] dlen_ff;
   logic       match_ff;
   logic       match_in;
   logic       match_now;
   logic       hit;
   logic       sel;
   kvtc_pkg::vote_type vote_ff;
   kvtc_pkg::vote_type vote_in;

   assign sel       = 32'(wr.entry_index) == CELL_ID;
   assign match_now = match_ff & (~ctl.compare | (rd_ff == word_char));
   assign hit       = match_now && (dlen_ff != 5'd0) && (32'(dlen_ff) == 32'(word_len))
                      && (32'(dlen_ff) <= WORD_LEN) && (32'(dclass_ff) < CLASSES);

   always_comb begin
      match_in = match_ff;
      if (ctl.clear) begin
         match_in = 1'b1;
      end else if (ctl.compare) begin
         match_in = match_now;
      end
      if (ctl.load) begin
         vote_in.valid = hit;
         vote_in.cls   = dclass_ff;
      end else begin
         vote_in = vote_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.char_we && sel) begin
         chars[AW'(wr.char_position)] <= wr.char_code;
      end
      rd_ff <= chars[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dclass_ff <= '0;
         dlen_ff   <= '0;
         match_ff  <= 1'b0;
         vote_ff   <= '0;
      end else begin
         if (ctl.tag_we && sel) begin
            dclass_ff <= wr.entry_class;
            dlen_ff   <= wr.entry_length;
         end
         match_ff <= match_in;
         vote_ff  <= vote_in;
      end
   end

   assign vote_out = vote_ff;

endmodule

// ===== sv/kvtc_score_bank.sv =====
// kvtc_score_bank: saturating per-class score registers and the best-class scan.
// Takes one vote a cycle from the end of the cell row.
// Depends on kvtc_pkg.
module kvtc_score_bank #(
   parameter int CLASSES = kvtc_pkg::CLASSES_DEF,
   localparam int CW = $clog2(CLASSES)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  kvtc_pkg::vote_type     vote,
   input  kvtc_pkg::bank_ctl_type ctl,
   input  logic [CW-1:0]          scan_idx,
   output logic [3:0]             best_class,
   output logic [15:0]            best_score
);

   logic [15:0]   scores_ff [CLASSES];
   logic [15:0]   scan_val;
   logic [CW-1:0] best_ff;
   logic [15:0]   best_score_ff;

   assign scan_val = scores_ff[scan_idx];

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         for (int k = 0; k < CLASSES; k++) begin
            scores_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < CLASSES; k++) begin
            if (vote.valid && (32'(vote.cls) == k) && (scores_ff[k] != kvtc_pkg::COUNT_MAX)) begin
               scores_ff[k] <= scores_ff[k] + 16'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.scan) begin
         if (ctl.scan_first) begin
            best_ff       <= '0;
            best_score_ff <= scan_val;
         end else if (scan_val > best_score_ff) begin
            best_ff       <= scan_idx;
            best_score_ff <= scan_val;
         end
      end
   end

   assign best_class = 4'(best_ff);
   assign best_score = best_score_ff;

endmodule

// ===== sv/keyword_vote_text_classifier_core.sv =====
// keyword_vote_text_classifier_core: text word splitter, sequencer and output register
// over a row of ENTRIES match cells and the class score bank.
// Text and load words: one per cycle while idle. A word of up to WORD_LEN chars ending
// in a space or end of text holds the input for character sweep, vote load and vote drain.
// End of text adds a class scan and a rsp_ready-gated emit; the result is registered.
// Synchronous reset clears entry tags, lengths, scores and counters; no clearing pass.
module keyword_vote_text_classifier_core #(
   parameter int CLASSES  = kvtc_pkg::CLASSES_DEF,
   parameter int ENTRIES  = kvtc_pkg::ENTRIES_DEF,
   parameter int WORD_LEN = kvtc_pkg::WORD_LEN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  kvtc_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output kvtc_pkg::rsp_type rsp_payload
);

   localparam int AW = $clog2(WORD_LEN);
   localparam int LW = $clog2(WORD_LEN + 1);
   localparam int CW = $clog2(CLASSES);
   localparam int DW = $clog2(ENTRIES + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CMP   = 3'd1;
   localparam logic [2:0] ST_LOAD  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_SCAN  = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   logic [2:0]    state_ff, state_in;
   logic [LW-1:0] wlen_ff, wlen_in;
   logic          overlong_ff, overlong_in;
   logic [15:0]   count_ff, count_in;
   logic          eot_ff, eot_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic          cmp_ff;
   logic [DW-1:0] drain_ff, drain_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic          rsp_valid_ff, rsp_valid_in;
   kvtc_pkg::rsp_type rsp_ff;
   logic          rsp_load;

   logic [7:0]    wbuf [WORD_LEN];
   logic [7:0]    wbuf_rd_ff;
   logic          wbuf_we;

   logic          acc;
   logic [7:0]    lc;
   logic          pending;
   logic [3:0]    best_class;
   logic [15:0]   best_score;

   kvtc_pkg::cell_ctl_type cell_ctl;
   kvtc_pkg::bank_ctl_type bank_ctl;
   kvtc_pkg::vote_type     votes [ENTRIES+1];

   assign req_ready = state_ff == ST_IDLE;
   assign acc       = req_valid && req_ready;
   assign lc        = to_lower(req_payload.char_code);
   assign pending   = (wlen_ff != '0) || overlong_ff;

   always_comb begin
      state_in     = state_ff;
      wlen_in      = wlen_ff;
      overlong_in  = overlong_ff;
      count_in     = count_ff;
      eot_in       = eot_ff;
      addr_in      = addr_ff;
      drain_in     = drain_ff;
      scan_in      = scan_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_load     = 1'b0;
      wbuf_we      = 1'b0;
      bank_ctl     = '0;
      cell_ctl.clear   = state_ff == ST_IDLE;
      cell_ctl.compare = cmp_ff;
      cell_ctl.load    = state_ff == ST_LOAD;
      cell_ctl.char_we = acc && (req_payload.kind == kvtc_pkg::KIND_CHAR)
                         && (32'(req_payload.char_position) < WORD_LEN);
      cell_ctl.tag_we  = acc && (req_payload.kind == kvtc_pkg::KIND_TAG);

      case (state_ff)
         ST_IDLE: begin
            if (acc && (req_payload.kind == kvtc_pkg::KIND_TEXT ||
                        req_payload.kind == kvtc_pkg::KIND_EOT)) begin
               if (req_payload.kind == kvtc_pkg::KIND_TEXT && lc != kvtc_pkg::SPACE_CODE) begin
                  if (32'(wlen_ff) < WORD_LEN) begin
                     wbuf_we = 1'b1;
                     wlen_in = LW'(wlen_ff + 1'b1);
                  end else begin
                     overlong_in = 1'b1;
                  end
               end else begin
                  if (req_payload.kind == kvtc_pkg::KIND_EOT) begin
                     eot_in   = 1'b1;
                     state_in = ST_SCAN;
                     scan_in  = '0;
                  end
                  if (pending) begin
                     if (count_ff != kvtc_pkg::COUNT_MAX) begin
                        count_in = count_ff + 16'd1;
                     end
                     if (overlong_ff) begin
                        wlen_in     = '0;
                        overlong_in = 1'b0;
                     end else begin
                        state_in = ST_CMP;
                        addr_in  = '0;
                     end
                  end
               end
            end
         end
         ST_CMP: begin
            addr_in = AW'(addr_ff + 1'b1);
            if (32'(addr_ff) == 32'(wlen_ff) - 1) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            wlen_in  = '0;
            drain_in = '0;
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            drain_in = DW'(drain_ff + 1'b1);
            if (32'(drain_ff) == ENTRIES - 1) begin
               if (eot_ff) begin
                  state_in = ST_SCAN;
                  scan_in  = '0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCAN: begin
            bank_ctl.scan       = 1'b1;
            bank_ctl.scan_first = scan_ff == '0;
            scan_in             = CW'(scan_ff + 1'b1);
            if (32'(scan_ff) == CLASSES - 1) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load       = 1'b1;
               rsp_valid_in   = 1'b1;
               bank_ctl.clear = 1'b1;
               count_in       = '0;
               eot_in         = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wbuf_we) begin
         wbuf[wlen_ff[AW-1:0]] <= lc;
      end
      wbuf_rd_ff <= wbuf[addr_ff];
      if (rsp_load) begin
         rsp_ff.best_class <= best_class;
         rsp_ff.best_score <= best_score;
         rsp_ff.words_seen <= count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wlen_ff      <= '0;
         overlong_ff  <= 1'b0;
         count_ff     <= '0;
         eot_ff       <= 1'b0;
         addr_ff      <= '0;
         cmp_ff       <= 1'b0;
         drain_ff     <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wlen_ff      <= wlen_in;
         overlong_ff  <= overlong_in;
         count_ff     <= count_in;
         eot_ff       <= eot_in;
         addr_ff      <= addr_in;
         cmp_ff       <= state_ff == ST_CMP;
         drain_ff     <= drain_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign votes[0] = '0;

   for (genvar e = 0; e < ENTRIES; e++) begin : g_cell
      kvtc_cell #(
         .CLASSES  (CLASSES),
         .WORD_LEN (WORD_LEN),
         .CELL_ID  (e)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl),
         .wr        (req_payload),
         .rd_addr   (addr_ff),
         .word_char (wbuf_rd_ff),
         .word_len  (wlen_ff),
         .vote_prev (votes[e]),
         .vote_out  (votes[e+1])
      );
   end

   kvtc_score_bank #(
      .CLASSES (CLASSES)
   ) u_bank (
      .clock      (clock),
      .reset      (reset),
      .vote       (votes[ENTRIES]),
      .ctl        (bank_ctl),
      .scan_idx   (scan_ff),
      .best_class (best_class),
      .best_score (best_score)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
